// ===== src/otp_multiset_table_ring_top_macros.svh =====
// Assertion macros for the OTP table ring
`ifndef OTP_MULTISET_TABLE_RING_TOP_MACROS_SVH
`define OTP_MULTISET_TABLE_RING_TOP_MACROS_SVH

// Concurrent check on rising clk, held off during reset
`define OTPR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check that also holds during reset
`define OTPR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/otpr_pkg.sv =====
`timescale 1ns / 1ps
package otpr_pkg;
  localparam int MaxSlots  = 256;
  localparam int MaxTables = 4;
  localparam int SlotW     = $clog2(MaxSlots);
  localparam int TblW      = (MaxTables > 1) ? $clog2(MaxTables) : 1;
  localparam int AddrW     = SlotW + TblW;
  localparam int CntW      = $clog2(MaxSlots + 1);
  localparam int RingW     = $clog2(MaxTables + 1);
  localparam int SweepW    = $clog2(MaxSlots * MaxTables + 1);

  localparam logic [2:0] KIND_BEGIN  = 3'd0;
  localparam logic [2:0] KIND_ADD    = 3'd1;
  localparam logic [2:0] KIND_FINISH = 3'd2;
  localparam logic [2:0] KIND_CHECK  = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;

  localparam logic CFG_OTPS = 1'b0;
  localparam logic CFG_RING = 1'b1;

  typedef enum logic [1:0] {
    SLOT_FREE,
    SLOT_HIT,
    SLOT_MISS
  } slot_res_t;

  // controller -> datapath
  typedef struct packed {
    logic            load;      // capture item
    logic            mod_step;  // one restoring step of pw mod n
    logic            read;      // issue slot read at probe address
    logic            write_add; // write slot for add
    logic            write_chk; // decrement slot count
    logic            advance;   // step probe position
    logic            wipe;      // wipe one slot of the clear pass
    logic [TblW-1:0] tbl;       // table being probed / wiped
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    slot_res_t       res;
    logic            cnt_zero;  // matched slot has no uses left
    logic            probe_end; // probed all slots
    logic            wipe_end;  // clear pass at last slot
  } dp_sts_t;
endpackage

// ===== src/otpr_datapath.sv =====
`timescale 1ns / 1ps
module otpr_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  otpr_pkg::dp_cmd_t      cmd,
  output otpr_pkg::dp_sts_t      sts,
  input  logic [31:0]            in_otp_value,
  input  logic [otpr_pkg::CntW-1:0] slot_n
);
  import otpr_pkg::*;

  logic [31:0]      pw_r;
  logic [CntW-1:0]  rem_r;     // restoring remainder, shifted window
  logic [5:0]       mstep_r;
  logic [SlotW-1:0] pos_r;
  logic [CntW-1:0]  probed_r;
  logic [SlotW-1:0] wpos_r;

  logic [31:0]      mem_val [MaxTables*MaxSlots];
  logic [8:0]       mem_meta [MaxTables*MaxSlots]; // {empty, count}
  logic [31:0]      rd_val_r;
  logic [8:0]       rd_meta_r;

  logic [AddrW-1:0] addr;
  logic [AddrW-1:0] waddr;
  logic [CntW:0]    trial;
  logic [CntW:0]    rshift;
  logic             wr_en;
  logic [8:0]       wr_meta;
  logic [CntW-1:0]  nxt_pos;

  assign addr  = {cmd.tbl, pos_r};
  assign waddr = cmd.wipe ? {cmd.tbl, wpos_r} : addr;

  // remainder: one bit of pw per mod step
  assign rshift = {rem_r, pw_r[31]};
  assign trial  = rshift - {1'b0, slot_n};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pw_r     <= in_otp_value;
      rem_r    <= '0;
      mstep_r  <= '0;
      probed_r <= '0;
    end else if (cmd.mod_step) begin
      pw_r    <= {pw_r[30:0], pw_r[31]};
      rem_r   <= trial[CntW] ? rshift[CntW-1:0] : trial[CntW-1:0];
      mstep_r <= mstep_r + 6'd1;
      if (mstep_r == 6'd31) begin
        pos_r <= trial[CntW] ? rshift[SlotW-1:0] : trial[SlotW-1:0];
      end
    end else if (cmd.advance) begin
      pos_r    <= nxt_pos[SlotW-1:0];
      probed_r <= probed_r + 1'b1;
    end
  end

  assign nxt_pos = ({1'b0, pos_r} + 1'b1 == slot_n) ? '0 : {1'b0, pos_r} + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) wpos_r <= '0;
    else if (cmd.wipe) wpos_r <= wpos_r + 1'b1;
  end

  always_comb begin
    wr_en   = cmd.wipe | cmd.write_add | cmd.write_chk;
    wr_meta = 9'h100;
    if (cmd.write_add) begin
      if (rd_meta_r[8]) wr_meta = 9'd1;
      else wr_meta = {1'b0, (rd_meta_r[7:0] == 8'hFF) ? 8'hFF : rd_meta_r[7:0] + 8'd1};
    end else if (cmd.write_chk) begin
      wr_meta = {1'b0, rd_meta_r[7:0] - 8'd1};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_meta[waddr] <= wr_meta;
    if (cmd.write_add) mem_val[addr] <= pw_r;
    if (cmd.read) begin
      rd_val_r  <= mem_val[addr];
      rd_meta_r <= mem_meta[addr];
    end
  end

  always_comb begin
    sts = '0;
    if (rd_meta_r[8]) sts.res = SLOT_FREE;
    else if (rd_val_r == pw_r) sts.res = SLOT_HIT;
    else sts.res = SLOT_MISS;
    sts.cnt_zero  = (rd_meta_r[7:0] == 8'd0);
    sts.probe_end = (probed_r + 1'b1 >= slot_n);
    sts.wipe_end  = (wpos_r == SlotW'(MaxSlots - 1));
  end
endmodule

// ===== src/otpr_ctrl.sv =====
`timescale 1ns / 1ps
module otpr_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [2:0]              in_kind,
  input  logic [15:0]             in_seed_id,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_accepted,
  output logic                    out_error,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_index,
  input  logic [7:0]              cfg_data,
  output logic [otpr_pkg::CntW-1:0] slot_n,
  output otpr_pkg::dp_cmd_t       cmd,
  input  otpr_pkg::dp_sts_t       sts
);
  import otpr_pkg::*;
  `include "otp_multiset_table_ring_top_macros.svh"

  typedef enum logic [7:0] {
    S_INIT  = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_MOD   = 8'b00000100,
    S_READ  = 8'b00001000,
    S_WAIT  = 8'b00010000,
    S_EVAL  = 8'b00100000,
    S_WIPE  = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;
  logic [7:0]      otps_r;
  logic [2:0]      ring_cfg_r;
  logic [15:0]     tag_r [MaxTables];
  logic [RingW-1:0] used_r, used_nxt;
  logic [TblW-1:0] next_r, next_nxt;
  logic            gen_r, gen_nxt;
  logic [2:0]      kind_r;
  logic [15:0]     seed_r;
  logic [TblW-1:0] tbl_r, tbl_nxt;
  logic            acc_r, acc_nxt, err_r, err_nxt;
  logic            tag_we;
  logic [5:0]      mcnt_r;
  logic            pw_done;

  logic [RingW-1:0] nt;
  logic [RingW-1:0] cur_w;
  logic [TblW-1:0]  cur;
  logic [8:0]       s2;
  logic [RingW-1:0] lim;
  logic             found;
  logic [TblW-1:0]  found_t;
  logic [RingW:0]   tsum;
  logic [TblW-1:0]  tcand;

  always_comb begin
    s2 = {otps_r, 1'b0};
    if (s2 < 9'd2) slot_n = CntW'(2);
    else if (s2 > 9'(MaxSlots)) slot_n = CntW'(MaxSlots);
    else slot_n = CntW'(s2);
    if (ring_cfg_r < 3'd1) nt = RingW'(1);
    else if (32'(ring_cfg_r) > MaxTables) nt = RingW'(MaxTables);
    else nt = RingW'(ring_cfg_r);
    // next_r mod nt; a ring shrink can leave next_r several tables past the end
    cur_w = RingW'(next_r);
    for (int k = 0; k < MaxTables; k++) begin
      if (cur_w >= nt) cur_w = cur_w - nt;
    end
    cur = cur_w[TblW-1:0];
    lim = (used_r < nt) ? used_r : nt;
  end

  // newest matching table, searched over at most MaxTables entries
  always_comb begin
    found   = 1'b0;
    found_t = '0;
    tsum    = '0;
    tcand   = '0;
    for (int i = 1; i <= MaxTables; i++) begin
      tsum  = (RingW+1)'(cur) + (RingW+1)'(nt) - (RingW+1)'(i);
      tcand = (tsum >= (RingW+1)'(nt)) ? TblW'(tsum - (RingW+1)'(nt)) : TblW'(tsum);
      if (!found && (RingW'(i) <= lim) && !(tcand == cur && gen_r) &&
          tag_r[tcand] == seed_r) begin
        found   = 1'b1;
        found_t = tcand;
      end
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) || (state_r == S_INIT);
  assign out_valid = (state_r == S_OUT);
  assign out_accepted = acc_r;
  assign out_error    = err_r;

  always_comb begin
    state_nxt = state_r;
    used_nxt  = used_r;
    next_nxt  = next_r;
    gen_nxt   = gen_r;
    tbl_nxt   = tbl_r;
    acc_nxt   = acc_r;
    err_nxt   = err_r;
    tag_we    = 1'b0;
    cmd       = '0;
    cmd.tbl   = tbl_r;
    unique case (state_r)
      S_INIT: begin
        cmd.wipe = 1'b1;
        if (sts.wipe_end) begin
          if (tbl_r == TblW'(MaxTables - 1)) state_nxt = S_IDLE;
          tbl_nxt = tbl_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          acc_nxt   = 1'b0;
          err_nxt   = 1'b0;
          state_nxt = S_OUT;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        unique case (kind_r)
          KIND_ADD: tbl_nxt = cur;
          default:  tbl_nxt = found_t;
        endcase
        if (kind_r == KIND_CHECK && !found) state_nxt = S_OUT;
        else if (pw_done) state_nxt = S_READ;
      end
      S_READ: begin
        cmd.read  = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: state_nxt = S_EVAL;
      S_EVAL: begin
        state_nxt = S_OUT;
        if (kind_r == KIND_ADD) begin
          if (sts.res != SLOT_MISS) cmd.write_add = 1'b1;
          else if (sts.probe_end) err_nxt = 1'b1;
          else begin
            cmd.advance = 1'b1;
            state_nxt   = S_READ;
          end
        end else begin
          if (sts.res == SLOT_HIT) begin
            if (!sts.cnt_zero) begin
              cmd.write_chk = 1'b1;
              acc_nxt       = 1'b1;
            end
          end else if (sts.res == SLOT_MISS && !sts.probe_end) begin
            cmd.advance = 1'b1;
            state_nxt   = S_READ;
          end
        end
      end
      S_WIPE: begin
        cmd.wipe = 1'b1;
        if (sts.wipe_end) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase

    // item dispatch on the load cycle
    if (state_r == S_IDLE && in_valid) begin
      unique case (in_kind)
        KIND_BEGIN: begin
          tag_we    = 1'b1;
          next_nxt  = cur;
          gen_nxt   = 1'b1;
          tbl_nxt   = cur;
          state_nxt = S_WIPE;
        end
        KIND_ADD: if (gen_r) state_nxt = S_MOD;
        KIND_FINISH: if (gen_r) begin
          gen_nxt  = 1'b0;
          next_nxt = (RingW'(cur) + 1'b1 == nt) ? '0 : cur + 1'b1;
          if (used_r < nt) used_nxt = used_r + 1'b1;
        end
        KIND_CHECK: state_nxt = S_MOD;
        KIND_CLEAR: begin
          gen_nxt  = 1'b0;
          used_nxt = '0;
          next_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) mcnt_r <= '0;
    else if (cmd.mod_step) mcnt_r <= mcnt_r + 6'd1;
  end
  assign pw_done = (mcnt_r == 6'd31);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      otps_r     <= 8'd128;
      ring_cfg_r <= 3'd4;
      used_r     <= '0;
      next_r     <= '0;
      gen_r      <= 1'b0;
      tbl_r      <= '0;
      acc_r      <= 1'b0;
      err_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      next_r  <= next_nxt;
      gen_r   <= gen_nxt;
      tbl_r   <= tbl_nxt;
      acc_r   <= acc_nxt;
      err_r   <= err_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_OTPS) otps_r <= cfg_data;
        else ring_cfg_r <= cfg_data[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      seed_r <= in_seed_id;
    end
    if (tag_we) tag_r[cur] <= in_seed_id;
  end

  `OTPR_ASSERT(a_gen_ring, used_r <= RingW'(MaxTables), "used tables exceed ring")
  `OTPR_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(acc_r),
               "result dropped under stall")
  `OTPR_ASSERT(a_one_flag, !(acc_r && err_r), "accept and error together")
endmodule

// ===== src/otp_multiset_table_ring_top.sv =====
`timescale 1ns / 1ps
// OTP table ring: a ring of hash multisets holding one-time passwords.
// Input channel (in_valid/in_stall) carries kind, seed_id, otp_value; each
// item yields exactly one result beat on out_valid/out_stall with accepted
// and error flags. Config writes (cfg_valid/cfg_ready) set otps_per_seed
// (index 0) and tables_in_ring (index 1) while the block is idle.
// Items are taken one at a time; in_stall is high while an item is in work.
// Finish, remove-all, ignored kinds and adds while not generating go
// straight to the result beat; a check with no matching table goes there
// after its first remainder step; begin wipes 256 slots, one per cycle;
// other adds and checks run the load, 32 steps of serial remainder, one
// bit of the password per cycle, a read, wait and evaluate step per probed
// slot through the slot memory's registered read port, and the result beat.
// After reset a clearing pass wipes all 1024 slots, one per cycle, before
// the first item is taken; config writes are taken during it.
// A stalled result holds its flags until taken; no new item enters meanwhile.
module otp_multiset_table_ring_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [15:0] in_seed_id,
  input  logic [31:0] in_otp_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_accepted,
  output logic        out_error,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import otpr_pkg::*;

  dp_cmd_t         cmd;
  dp_sts_t         sts;
  logic [CntW-1:0] slot_n;

  otpr_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_kind, .in_seed_id,
    .out_valid, .out_stall, .out_accepted, .out_error,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .slot_n, .cmd, .sts
  );

  otpr_datapath u_dp (
    .clk, .rst_n, .cmd, .sts, .in_otp_value, .slot_n
  );
endmodule
